[design/two_ray_midpoint_triangulation_core_defines.svh]
// Assertion macros shared by the triangulation core checker.
`ifndef TWO_RAY_MIDPOINT_TRIANGULATION_CORE_DEFINES_SVH
`define TWO_RAY_MIDPOINT_TRIANGULATION_CORE_DEFINES_SVH

// Property that is checked at every clock edge, reset included.
`define TRM_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("triangulation core check failed");

// Property that is not checked while reset is asserted.
`define TRM_CHECK_RUN(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("triangulation core check failed");

`endif

[design/trm_pkg.sv]
// Shared types, constants and the output saturation function of the triangulation core.
`default_nettype none

package trm_pkg;

  // Coordinate word width; the request and result fields use it.
  localparam int COORD_W = 32;

  // Reset value of the parallel-ray threshold (about 1e-6 in Q0.32).
  localparam logic [31:0] MIN_DEN_RESET = 32'd4295;

  // Wide multiplier layout: 32-bit digits, up to 16 tiles, a 4-level adder tree.
  localparam int DIGIT_W    = 32;
  localparam int MUL_LEAVES = 16;
  localparam int MUL_LVLS   = 4;
  localparam int MUL_NODES  = 2 * MUL_LEAVES - 1;
  localparam int MUL_LAT    = MUL_LVLS + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin1_x;
    logic signed [COORD_W-1:0] origin1_y;
    logic signed [COORD_W-1:0] origin1_z;
    logic signed [COORD_W-1:0] dir1_x;
    logic signed [COORD_W-1:0] dir1_y;
    logic signed [COORD_W-1:0] dir1_z;
    logic signed [COORD_W-1:0] origin2_x;
    logic signed [COORD_W-1:0] origin2_y;
    logic signed [COORD_W-1:0] origin2_z;
    logic signed [COORD_W-1:0] dir2_x;
    logic signed [COORD_W-1:0] dir2_y;
    logic signed [COORD_W-1:0] dir2_z;
  } ray_pair_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      rays_parallel;
  } point_t;

  // Turns an unsigned quotient and its sign into a saturated coordinate.
  // Negative results round toward minus infinity when the division was inexact.
  function automatic logic [COORD_W-1:0] sat_quot(input logic [COORD_W-1:0] q,
                                                  input logic inexact,
                                                  input logic ovf,
                                                  input logic neg);
    logic [COORD_W:0]   mag;
    logic [COORD_W-1:0] pmax;
    logic [COORD_W-1:0] nmin;
    pmax = {1'b0, {(COORD_W-1){1'b1}}};
    nmin = {1'b1, {(COORD_W-1){1'b0}}};
    mag  = {1'b0, q} + {{COORD_W{1'b0}}, inexact};
    if (ovf) begin
      return neg ? nmin : pmax;
    end else if (!neg) begin
      return q[COORD_W-1] ? pmax : q;
    end else if (mag > {1'b0, nmin}) begin
      return nmin;
    end else begin
      return COORD_W'(-mag);
    end
  endfunction

endpackage

`default_nettype wire

[design/trm_dly.sv]
// Enabled shift line that keeps side data aligned with the pipeline.
`default_nettype none

module trm_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [N];

  // Every tap advances with the pipeline enable.
  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule

`default_nettype wire

[design/trm_mul.sv]
// Pipelined exact signed multiplier built from 33x33 tiles and a registered adder tree.
`default_nettype none

module trm_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int PW  = AW + BW;
  localparam int DG  = trm_pkg::DIGIT_W;
  localparam int DG1 = DG + 1;
  localparam int NA  = (AW - 1) / DG + 1;
  localparam int NB  = (BW - 1) / DG + 1;
  localparam int NT  = NA * NB;
  localparam int LV  = trm_pkg::MUL_LEAVES;

  logic signed [DG1-1:0] da [NA];
  logic signed [DG1-1:0] db [NB];
  logic signed [PW-1:0]  node [trm_pkg::MUL_NODES];

  // Lower digits are unsigned, the top digit carries the sign.
  for (genvar i = 0; i < NA; i++) begin : g_da
    if (i < NA - 1) begin : g_lo
      assign da[i] = {1'b0, a[DG*i +: DG]};
    end else begin : g_hi
      assign da[i] = DG1'($signed(a[AW-1:DG*i]));
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_db
    if (j < NB - 1) begin : g_lo
      assign db[j] = {1'b0, b[DG*j +: DG]};
    end else begin : g_hi
      assign db[j] = DG1'($signed(b[BW-1:DG*j]));
    end
  end

  // Tile products, each placed at its digit weight.
  for (genvar t = 0; t < LV; t++) begin : g_leaf
    if (t < NT) begin : g_tile
      logic signed [2*DG1-1:0] tile;
      assign tile = da[t / NB] * db[t % NB];
      always_ff @(posedge clk) begin
        if (en) begin
          node[t] <= PW'(tile) <<< (DG * (t / NB + t % NB));
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        if (en) begin
          node[t] <= '0;
        end
      end
    end
  end

  // Registered binary adder tree; the sum is exact modulo 2^PW.
  for (genvar l = 1; l <= trm_pkg::MUL_LVLS; l++) begin : g_lvl
    localparam int BASE = 2 * LV - ((2 * LV) >> l);
    localparam int PREV = 2 * LV - ((2 * LV) >> (l - 1));
    for (genvar k = 0; k < (LV >> l); k++) begin : g_add
      always_ff @(posedge clk) begin
        if (en) begin
          node[BASE+k] <= node[PREV+2*k] + node[PREV+2*k+1];
        end
      end
    end
  end

  assign p = node[trm_pkg::MUL_NODES-1];

endmodule

`default_nettype wire

[design/trm_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
`default_nettype none

module trm_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic [QW-1:0] q,
  output logic          rem_nz,
  output logic          ovf
);

  localparam int CMPW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [DW-1:0] rem [QW+1];
  logic [QW-1:0] quo [QW+1];
  logic          ovr [QW+1];
  logic [QW-1:0] low [QW];
  logic [DW-1:0] dv  [QW];

  // Setup: a quotient that does not fit in QW bits is flagged, the upper
  // dividend bits seed the partial remainder.
  always_ff @(posedge clk) begin
    if (en) begin
      ovr[0] <= CMPW'(n) >= (CMPW'(d) << QW);
      rem[0] <= DW'(n >> QW);
      low[0] <= n[QW-1:0];
      quo[0] <= '0;
      dv[0]  <= d;
    end
  end

  // One trial subtraction per stage, most significant quotient bit first.
  for (genvar j = 1; j <= QW; j++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem[j-1], low[j-1][QW-1]};
    assign ge    = trial >= {1'b0, dv[j-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= ge ? DW'(trial - {1'b0, dv[j-1]}) : trial[DW-1:0];
        quo[j] <= {quo[j-1][QW-2:0], ge};
        ovr[j] <= ovr[j-1];
      end
    end

    if (j < QW) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          low[j] <= low[j-1] << 1;
          dv[j]  <= dv[j-1];
        end
      end
    end
  end

  assign q      = quo[QW];
  assign rem_nz = |rem[QW];
  assign ovf    = ovr[QW];

endmodule

`default_nettype wire

[design/two_ray_midpoint_triangulation_core.sv]
// Two-ray midpoint triangulation core, fully pipelined at one request per cycle unless the output stalls.
//
// Requests arrive on ray_valid/ray_ready with a ray_pair_t payload (two origins
// and two directions in signed Q16.16); results leave on point_valid/point_ready
// as a point_t (saturated midpoint and a flag for near-parallel rays).
// cfg_valid/cfg_ready writes the parallel-ray threshold min_denominator
// (Q0.32); cfg_ready is always high and the block should be idle during a write.
// From the accepting edge to point_valid a request passes through
// the origin sum stage, the product stage, the dot-sum stage, a 5-stage tiled
// multiplier, the solve terms, a second 5-stage multiplier, two adder stages,
// the magnitude stage, a divider with a setup stage and one quotient bit per
// stage, and the output register.
// Throughput is one request per cycle while point_ready is high.
// The whole pipeline advances on one enable; when the output register holds
// an unaccepted result, ray_ready drops and every stage holds its contents.
// Synchronous reset clears all valid bits and restores the threshold to 4295.
`default_nettype none

module two_ray_midpoint_triangulation_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              ray_valid,
  output logic              ray_ready,
  input  trm_pkg::ray_pair_t ray,
  output logic              point_valid,
  input  logic              point_ready,
  output trm_pkg::point_t   point,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);

  localparam int CW     = trm_pkg::COORD_W;
  localparam int K      = CW;
  localparam int SW     = CW + 1;
  localparam int PRW    = 2 * SW;
  localparam int EW     = 2 * CW + 3;
  localparam int DW     = 2 * EW + 1;
  localparam int PW     = SW + DW;
  localparam int MW     = PW + 2;
  localparam int THRW   = 4 * FRAC_BITS;
  localparam int THR_SH = 4 * FRAC_BITS - 32;
  localparam int CMPW   = ((DW > THRW) ? DW : THRW) + 1;
  localparam int ML     = trm_pkg::MUL_LAT;
  localparam int LAT    = 2 * ML + 9 + K;

  logic           en;
  logic [LAT:1]   vld;
  logic [31:0]    min_den;
  logic [THRW-1:0] thr;

  logic signed [CW-1:0] o1 [3];
  logic signed [CW-1:0] o2 [3];
  logic signed [CW-1:0] u1 [3];
  logic signed [CW-1:0] u2 [3];

  logic signed [SW-1:0]  s_l1 [3];
  logic signed [SW-1:0]  r_l1 [3];
  logic signed [CW-1:0]  dir1_l1 [3];
  logic signed [CW-1:0]  dir2_l1 [3];
  logic signed [PRW-1:0] paa [3];
  logic signed [PRW-1:0] pab [3];
  logic signed [PRW-1:0] pbb [3];
  logic signed [PRW-1:0] par_ [3];
  logic signed [PRW-1:0] pbr [3];
  logic signed [EW-1:0]  dot_a;
  logic signed [EW-1:0]  dot_b;
  logic signed [EW-1:0]  dot_c;
  logic signed [EW-1:0]  dot_d;
  logic signed [EW-1:0]  dot_e;
  logic signed [2*EW-1:0] ac;
  logic signed [2*EW-1:0] bb;
  logic signed [2*EW-1:0] dc;
  logic signed [2*EW-1:0] be;
  logic signed [2*EW-1:0] bd;
  logic signed [2*EW-1:0] ae;
  logic signed [DW-1:0]  den;
  logic signed [DW-1:0]  num1;
  logic signed [DW-1:0]  num2;
  logic                  par_l10;
  logic [DW-1:0]         den_l14;
  logic [DW-1:0]         den_l17;
  logic [DW-1:0]         divisor;
  logic [3*CW-1:0]       half_l1;
  logic [3*CW-1:0]       half_q;
  logic                  par_q;

  // Pipeline enable: everything moves unless the output register is stalled.
  assign en          = !vld[LAT] || point_ready;
  assign ray_ready   = en;
  assign point_valid = vld[LAT];
  assign cfg_ready   = 1'b1;

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], ray_valid};
    end
  end

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_den <= trm_pkg::MIN_DEN_RESET;
    end else if (cfg_valid) begin
      min_den <= cfg_data;
    end
  end

  assign thr = THRW'(min_den) << THR_SH;

  // Unpack the request into per-axis vectors.
  always_comb begin
    o1[0] = ray.origin1_x;  o1[1] = ray.origin1_y;  o1[2] = ray.origin1_z;
    u1[0] = ray.dir1_x;     u1[1] = ray.dir1_y;     u1[2] = ray.dir1_z;
    o2[0] = ray.origin2_x;  o2[1] = ray.origin2_y;  o2[2] = ray.origin2_z;
    u2[0] = ray.dir2_x;     u2[1] = ray.dir2_y;     u2[2] = ray.dir2_z;
  end

  // Stage 1: origin sum and difference.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s_l1[k]    <= SW'(o1[k]) + SW'(o2[k]);
        r_l1[k]    <= SW'(o2[k]) - SW'(o1[k]);
        dir1_l1[k] <= u1[k];
        dir2_l1[k] <= u2[k];
      end
    end
  end

  // Stage 2: the fifteen per-axis products of the five dot products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        paa[k]  <= SW'(dir1_l1[k]) * SW'(dir1_l1[k]);
        pab[k]  <= SW'(dir1_l1[k]) * SW'(dir2_l1[k]);
        pbb[k]  <= SW'(dir2_l1[k]) * SW'(dir2_l1[k]);
        par_[k] <= SW'(dir1_l1[k]) * r_l1[k];
        pbr[k]  <= SW'(dir2_l1[k]) * r_l1[k];
      end
    end
  end

  // Stage 3: dot product sums.
  always_ff @(posedge clk) begin
    if (en) begin
      dot_a <= EW'(paa[0]) + EW'(paa[1]) + EW'(paa[2]);
      dot_b <= EW'(pab[0]) + EW'(pab[1]) + EW'(pab[2]);
      dot_c <= EW'(pbb[0]) + EW'(pbb[1]) + EW'(pbb[2]);
      dot_d <= EW'(par_[0]) + EW'(par_[1]) + EW'(par_[2]);
      dot_e <= EW'(pbr[0]) + EW'(pbr[1]) + EW'(pbr[2]);
    end
  end

  // Stages 4 to 8: the six wide products of the 2x2 solve.
  trm_mul #(.AW(EW), .BW(EW)) u_mul_ac (.clk, .en, .a(dot_a), .b(dot_c), .p(ac));
  trm_mul #(.AW(EW), .BW(EW)) u_mul_bb (.clk, .en, .a(dot_b), .b(dot_b), .p(bb));
  trm_mul #(.AW(EW), .BW(EW)) u_mul_dc (.clk, .en, .a(dot_d), .b(dot_c), .p(dc));
  trm_mul #(.AW(EW), .BW(EW)) u_mul_be (.clk, .en, .a(dot_b), .b(dot_e), .p(be));
  trm_mul #(.AW(EW), .BW(EW)) u_mul_bd (.clk, .en, .a(dot_b), .b(dot_d), .p(bd));
  trm_mul #(.AW(EW), .BW(EW)) u_mul_ae (.clk, .en, .a(dot_a), .b(dot_e), .p(ae));

  // Stage 9: denominator and the two numerators. The denominator is never
  // negative (Cauchy-Schwarz), so no sign flip is needed later.
  always_ff @(posedge clk) begin
    if (en) begin
      den  <= DW'(ac) - DW'(bb);
      num1 <= DW'(dc) - DW'(be);
      num2 <= DW'(bd) - DW'(ae);
    end
  end

  // Stage 10: parallel-ray decision.
  always_ff @(posedge clk) begin
    if (en) begin
      par_l10 <= (CMPW'($unsigned(den)) < CMPW'(thr)) || (den == '0);
    end
  end

  trm_dly #(.W(1), .N(ML + 3 + K)) u_dly_par (.clk, .en, .d(par_l10), .q(par_q));
  trm_dly #(.W(DW), .N(ML)) u_dly_den14 (.clk, .en, .d(den), .q(den_l14));
  trm_dly #(.W(DW), .N(ML + 3)) u_dly_den17 (.clk, .en, .d(den), .q(den_l17));

  // Divisor is twice the denominator.
  assign divisor = {den_l17[DW-2:0], 1'b0};

  // Origin midpoint for the parallel case, rounded half up.
  for (genvar k = 0; k < 3; k++) begin : g_half
    logic signed [SW-1:0] sp1;
    assign sp1 = s_l1[k] + SW'(1);
    assign half_l1[CW*k +: CW] = CW'(sp1 >>> 1);
  end

  trm_dly #(.W(3*CW), .N(2*ML + 7 + K)) u_dly_half (.clk, .en, .d(half_l1), .q(half_q));

  // Per-axis back end: weighted sum, rounding offset, division, saturation.
  logic [CW-1:0] sat [3];

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic [SW+2*CW-1:0]      mid_d;
    logic [SW+2*CW-1:0]      mid_q;
    logic signed [SW-1:0]    s_l9;
    logic signed [CW-1:0]    dir1_l9;
    logic signed [CW-1:0]    dir2_l9;
    logic signed [PW-1:0]    ps;
    logic signed [DW+CW-1:0] p1;
    logic signed [DW+CW-1:0] p2;
    logic signed [MW-1:0]    sum_u;
    logic signed [MW-1:0]    sum_w;
    logic signed [MW-1:0]    sum_m;
    logic [MW-1:0]           nabs;
    logic                    neg_l17;
    logic                    neg_q;
    logic [K-1:0]            quot;
    logic                    rem_nz;
    logic                    ovf;

    assign mid_d   = {s_l1[k], dir1_l1[k], dir2_l1[k]};
    trm_dly #(.W(SW + 2*CW), .N(ML + 3)) u_dly_mid (.clk, .en, .d(mid_d), .q(mid_q));
    assign s_l9    = mid_q[SW+2*CW-1 -: SW];
    assign dir1_l9 = mid_q[2*CW-1 -: CW];
    assign dir2_l9 = mid_q[CW-1:0];

    // Stages 10 to 14: (o1+o2)*den, num1*dir1, num2*dir2.
    trm_mul #(.AW(SW), .BW(DW)) u_mul_s  (.clk, .en, .a(s_l9), .b(den), .p(ps));
    trm_mul #(.AW(DW), .BW(CW)) u_mul_n1 (.clk, .en, .a(num1), .b(dir1_l9), .p(p1));
    trm_mul #(.AW(DW), .BW(CW)) u_mul_n2 (.clk, .en, .a(num2), .b(dir2_l9), .p(p2));

    // Stages 15 and 16: numerator plus den for round-to-nearest.
    always_ff @(posedge clk) begin
      if (en) begin
        sum_u <= MW'(ps) + MW'(p1);
        sum_w <= MW'(p2) + MW'($signed(den_l14));
        sum_m <= sum_u + sum_w;
      end
    end

    // Stage 17: magnitude and sign for the unsigned divider.
    always_ff @(posedge clk) begin
      if (en) begin
        neg_l17 <= sum_m[MW-1];
        nabs    <= sum_m[MW-1] ? MW'(-sum_m) : MW'(sum_m);
      end
    end

    trm_dly #(.W(1), .N(K + 1)) u_dly_neg (.clk, .en, .d(neg_l17), .q(neg_q));

    trm_div #(.NW(MW), .DW(DW), .QW(K)) u_div (
      .clk, .en, .n(nabs), .d(divisor), .q(quot), .rem_nz(rem_nz), .ovf(ovf)
    );

    assign sat[k] = trm_pkg::sat_quot(quot, rem_nz, ovf, neg_q);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      point.point_x       <= par_q ? half_q[CW-1:0]      : sat[0];
      point.point_y       <= par_q ? half_q[2*CW-1 -: CW] : sat[1];
      point.point_z       <= par_q ? half_q[3*CW-1 -: CW] : sat[2];
      point.rays_parallel <= par_q;
    end
  end

endmodule

`default_nettype wire

[design/trm_checker.sv]
// Port-level checker for the triangulation core and its bind.
`default_nettype none

`include "two_ray_midpoint_triangulation_core_defines.svh"

module trm_checker (
  input logic            clk,
  input logic            rst,
  input logic            ray_ready,
  input logic            point_valid,
  input logic            point_ready,
  input trm_pkg::point_t point
);

  // A stalled result stays valid and unchanged.
  `TRM_CHECK_RUN(a_out_hold, (point_valid && !point_ready) |=> (point_valid && $stable(point)))

  // Reset empties the pipeline.
  `TRM_CHECK(a_rst_empty, rst |=> !point_valid)

  // With the output register empty the block takes a new request.
  `TRM_CHECK(a_ready_empty, !point_valid |-> ray_ready)

  // A stalled output register freezes the intake.
  `TRM_CHECK(a_stall_blocks, (point_valid && !point_ready) |-> !ray_ready)

endmodule

bind two_ray_midpoint_triangulation_core trm_checker u_trm_checker (.*);

`default_nettype wire
